/* rtl/ffsw_pkg.sv */
// Package for the flit FIFO with head-stall watchdog.
// Holds the sizes, the word structs and the operation, status and state codes.
// Has no dependencies.
package ffsw_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 64;
  localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int SEQ_W      = 32;
  localparam int LIMIT_W    = 5;
  localparam int THR_W      = 20;
  localparam int STALL_W    = 21;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;

  localparam logic [LIMIT_W-1:0]   LIMIT_RESET = LIMIT_W'(16);
  localparam logic [THR_W-1:0]     THR_RESET   = THR_W'(50000);
  localparam logic [STALL_W-1:0]   STALL_MAX   = {STALL_W{1'b1}};

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_TICK = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_DROPPED     = 2'd1,
    ST_EMPTY       = 2'd2,
    ST_FALSE_ALARM = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEPTH_LIMIT     = 1'b0,
    CFG_STALL_THRESHOLD = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_t;

  typedef struct packed {
    logic [1:0]            operation;
    logic [63:0]           flit_data;
    logic [SEQ_W-1:0]      flit_seq;
  } in_word_t;

  typedef struct packed {
    logic [63:0]           out_data;
    logic [SEQ_W-1:0]      out_seq;
    logic                  out_valid;
    logic [1:0]            status;
    logic [4:0]            occupancy;
    logic [4:0]            free_slots;
    logic [4:0]            peak_occupancy;
    logic                  stalled;
    logic                  deadlock_seen;
  } out_word_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] data;
    logic [SEQ_W-1:0]      seq;
  } ram_word_t;

  typedef struct packed {
    logic                  we;
    logic [PTR_W-1:0]      addr;
    ram_word_t             wdata;
  } ram_wr_t;

endpackage

/* rtl/flit_fifo_stall_watchdog_unit.sv */
// Top level of the flit FIFO with head-stall watchdog.
// Sequencer, item and result registers; uses ffsw_pkg, ffsw_ram and ffsw_core.
//
//   channel  | ports                                   | direction
//   ---------+-----------------------------------------+----------
//   input    | in_valid, in_stall, in_word             | in
//   result   | out_valid, out_stall, out_word          | out
//   config   | cfg_we, cfg_index, cfg_wdata            | in
//
// On accept the read of the head entry from the flit RAM starts; in the EXEC state
// the word then executes and loads the result register.
// A new word is taken while a result still waits in that register.
// Reset is synchronous; the flit RAM is not cleared and needs no clearing pass.
// When the result register is full and stalled, execution waits for it.
module flit_fifo_stall_watchdog_unit
  import ffsw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  fsm_t       state_r, state_nxt;
  in_word_t   item_r;
  out_word_t  out_word_r;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       commit;
  logic [PTR_W-1:0] head_ptr;
  ram_wr_t    ram_wr;
  ram_word_t  head_word;
  out_word_t  result;

  ffsw_ram #(
    .WIDTH ($bits(ram_word_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_wr.we),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.wdata),
    .re    (accept),
    .raddr (head_ptr),
    .rdata (head_word)
  );

  ffsw_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .commit    (commit),
    .item      (item_r),
    .head_word (head_word),
    .head_ptr  (head_ptr),
    .ram_wr    (ram_wr),
    .result    (result)
  );

  always_comb begin
    state_nxt     = state_r;
    in_stall      = 1'b1;
    accept        = 1'b0;
    commit        = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      FSM_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
        if (in_valid) begin
          state_nxt = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (!out_valid_r || !out_stall) begin
          commit        = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = FSM_IDLE;
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_word;
    end
    if (commit) begin
      out_word_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

/* rtl/ffsw_ram.sv */
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
module ffsw_ram #(
  parameter int WIDTH  = 96,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/ffsw_core.sv */
// Queue pointers, fill and peak counts, watchdog and configuration registers.
// Computes one result from the head entry read out of ffsw_ram; uses ffsw_pkg.
module ffsw_core
  import ffsw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  commit,
  input  in_word_t              item,
  input  ram_word_t             head_word,
  output logic [PTR_W-1:0]      head_ptr,
  output ram_wr_t               ram_wr,
  output out_word_t             result
);

  logic [LIMIT_W-1:0] depth_limit_r;
  logic [THR_W-1:0]   stall_thr_r;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [PTR_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [CNT_W-1:0]   peak_r, peak_nxt;
  logic [SEQ_W-1:0]   wseq_r, wseq_nxt;
  logic               wvalid_r, wvalid_nxt;
  logic [STALL_W-1:0] stall_r, stall_nxt;
  logic               dead_r, dead_nxt;
  logic [CNT_W-1:0]   limit;
  logic               stalled;
  status_t            status;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    if (depth_limit_r == '0) begin
      limit = CNT_W'(1);
    end else if (depth_limit_r > LIMIT_W'(DEPTH)) begin
      limit = CNT_W'(DEPTH);
    end else begin
      limit = CNT_W'(depth_limit_r);
    end
  end

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    fill_nxt   = fill_r;
    peak_nxt   = peak_r;
    wseq_nxt   = wseq_r;
    wvalid_nxt = wvalid_r;
    stall_nxt  = stall_r;
    dead_nxt   = dead_r;
    status     = ST_OK;
    ram_wr.we    = 1'b0;
    ram_wr.addr  = tail_r;
    ram_wr.wdata = '{data: item.flit_data[DATA_WIDTH-1:0], seq: item.flit_seq};
    result       = '0;
    case (op_t'(item.operation))
      OP_PUSH: begin
        if (fill_r >= limit) begin
          status = ST_DROPPED;
        end else begin
          ram_wr.we = commit;
          tail_nxt  = next_slot(tail_r);
          fill_nxt  = fill_r + CNT_W'(1);
          if (fill_nxt > peak_r) begin
            peak_nxt = fill_nxt;
          end
        end
      end
      OP_POP, OP_PEEK: begin
        if (fill_r == '0) begin
          status = ST_EMPTY;
        end else begin
          result.out_data  = 64'(head_word.data);
          result.out_seq   = head_word.seq;
          result.out_valid = 1'b1;
          if (op_t'(item.operation) == OP_POP) begin
            head_nxt = next_slot(head_r);
            fill_nxt = fill_r - CNT_W'(1);
          end
        end
      end
      OP_TICK: begin
        if (fill_r != '0) begin
          if (wvalid_r && wseq_r == head_word.seq) begin
            if (stall_r != STALL_MAX) begin
              stall_nxt = stall_r + STALL_W'(1);
            end
          end else begin
            if (dead_r) begin
              status = ST_FALSE_ALARM;
            end
            wseq_nxt   = head_word.seq;
            wvalid_nxt = 1'b1;
            stall_nxt  = '0;
          end
          if (stall_nxt > STALL_W'(stall_thr_r)) begin
            dead_nxt = 1'b1;
          end
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
    stalled               = stall_nxt > STALL_W'(stall_thr_r);
    result.status         = status;
    result.occupancy      = 5'(fill_nxt);
    result.free_slots     = (fill_nxt >= limit) ? 5'd0 : 5'(limit - fill_nxt);
    result.peak_occupancy = 5'(peak_nxt);
    result.stalled        = stalled;
    result.deadlock_seen  = dead_nxt;
  end

  assign head_ptr = head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_limit_r <= LIMIT_RESET;
      stall_thr_r   <= THR_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DEPTH_LIMIT:     depth_limit_r <= cfg_wdata[LIMIT_W-1:0];
        CFG_STALL_THRESHOLD: stall_thr_r   <= cfg_wdata[THR_W-1:0];
        default:             depth_limit_r <= depth_limit_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      fill_r   <= '0;
      peak_r   <= '0;
      wseq_r   <= '0;
      wvalid_r <= 1'b0;
      stall_r  <= '0;
      dead_r   <= 1'b0;
    end else if (commit) begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      fill_r   <= fill_nxt;
      peak_r   <= peak_nxt;
      wseq_r   <= wseq_nxt;
      wvalid_r <= wvalid_nxt;
      stall_r  <= stall_nxt;
      dead_r   <= dead_nxt;
    end
  end

endmodule
